// ===== rtl/core/rbs_pkg.sv =====
// Shared constants, types and face encoding for the ray/box slab test.
// Used by the top level, the pipelined divider lane and the port checker.
package rbs_pkg;

  // Coordinate format
  localparam int CW    = 32;          // coordinate width
  localparam int FB    = 16;          // fraction bits
  localparam int EW    = CW - 1;      // edge size width
  localparam int BW    = CW + 2;      // box bound width, signed
  localparam int NUMW  = CW + 3;      // bound minus origin, signed
  localparam int MAGW  = CW + 2;      // magnitude of that difference
  localparam int PRODW = CW + FB;     // scaled product magnitude
  localparam int PW    = CW + FB + 2; // hit point, signed
  localparam int DW    = PW + 1;      // hit point minus bound, signed

  // Divider: quotient bits retired per pipeline stage
  localparam int DSTEP  = 2;
  localparam int DIV_ST = CW / DSTEP;

  localparam int FACE_TOL_I = (1 << FB) / 1000;
  localparam logic signed [DW-1:0] FACE_TOL = DW'(FACE_TOL_I);

  localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [EW-1:0] EDGE_RESET = EW'(1 << FB);

  // Configuration register indexes
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_CENTER_X  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_CENTER_Y  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_CENTER_Z  = 2'd2;
  localparam logic [CFG_IW-1:0] REG_EDGE_SIZE = 2'd3;

  // Face codes
  localparam logic [2:0] FACE_NONE  = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_X = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Y = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;
  localparam logic [2:0] FACE_POS_Z = 3'd6;

  // One divider pipeline stage
  typedef struct packed {
    logic [CW-1:0] rem;
    logic [CW-1:0] den;
    logic [CW-1:0] nlo;
    logic [CW-1:0] quo;
    logic          sat;
  } div_stage_t;

  // One result
  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] t_entry;
    logic signed [CW-1:0] t_exit;
    logic [2:0]           entry_face;
    logic [2:0]           exit_face;
  } res_t;

  // Last face within tolerance wins, in order -x +x -y +y -z +z
  function automatic logic [2:0] face_code(input logic [2:0] lo_pass,
                                           input logic [2:0] hi_pass);
    logic [2:0] code;
    code = FACE_NONE;
    if (lo_pass[0]) code = FACE_NEG_X;
    if (hi_pass[0]) code = FACE_POS_X;
    if (lo_pass[1]) code = FACE_NEG_Y;
    if (hi_pass[1]) code = FACE_POS_Y;
    if (lo_pass[2]) code = FACE_NEG_Z;
    if (hi_pass[2]) code = FACE_POS_Z;
    return code;
  endfunction

  // Negate a face normal
  function automatic logic [2:0] face_flip(input logic [2:0] code);
    logic [2:0] res;
    unique case (code)
      FACE_NEG_X: res = FACE_POS_X;
      FACE_POS_X: res = FACE_NEG_X;
      FACE_NEG_Y: res = FACE_POS_Y;
      FACE_POS_Y: res = FACE_NEG_Y;
      FACE_NEG_Z: res = FACE_POS_Z;
      FACE_POS_Z: res = FACE_NEG_Z;
      default:    res = FACE_NONE;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/rbs_div.sv =====
// Pipelined restoring divider lane: (mag << FB) / den, with overflow flag.
// Depends on rbs_pkg; all stages advance only while en is high.
module rbs_div (
  input  logic                  clk,
  input  logic                  en,
  input  logic [rbs_pkg::MAGW-1:0] mag_i,
  input  logic [rbs_pkg::CW-1:0]   den_i,
  output logic [rbs_pkg::CW-1:0]   quo_o,
  output logic                     sat_o
);
  import rbs_pkg::*;

  div_stage_t stage_r [0:DIV_ST];
  div_stage_t init_nxt;

  // Retire DSTEP quotient bits
  function automatic div_stage_t div_steps(input div_stage_t cur);
    div_stage_t nx;
    logic [CW:0] trial;
    nx = cur;
    for (int i = 0; i < DSTEP; i++) begin
      trial  = {nx.rem, nx.nlo[CW-1]};
      nx.nlo = {nx.nlo[CW-2:0], 1'b0};
      if (trial >= {1'b0, nx.den}) begin
        nx.rem = CW'(trial - {1'b0, nx.den});
        nx.quo = {nx.quo[CW-2:0], 1'b1};
      end else begin
        nx.rem = trial[CW-1:0];
        nx.quo = {nx.quo[CW-2:0], 1'b0};
      end
    end
    return nx;
  endfunction

  // Flag quotients of 2^CW or more, seed remainder with the high dividend bits
  always_comb begin
    init_nxt.sat = ({{(CW+FB-MAGW){1'b0}}, mag_i} >= {den_i, {FB{1'b0}}});
    init_nxt.rem = CW'(mag_i >> (CW - FB));
    init_nxt.nlo = {mag_i[CW-FB-1:0], {FB{1'b0}}};
    init_nxt.den = den_i;
    init_nxt.quo = '0;
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      stage_r[0] <= init_nxt;
      for (int s = 1; s <= DIV_ST; s++) begin
        stage_r[s] <= div_steps(stage_r[s-1]);
      end
    end
  end

  assign quo_o = stage_r[DIV_ST].quo;
  assign sat_o = stage_r[DIV_ST].sat;

endmodule

// ===== rtl/core/ray_box_slab_intersect.sv =====
// Ray against axis-aligned cube, slab method, signed fixed point, pipelined.
// Depends on rbs_pkg and rbs_div.
//
// Usage:
//   Input channel in_*: one ray request (origin, direction) per valid cycle,
//   accepted when in_valid is high and in_stall is low.
//   Output channel out_*: one result per ray, in order, taken when out_valid
//   is high and out_stall is low. A miss returns all fields zero.
//   Config port cfg_*: write center_x/y/z and edge_size while idle.
// Path: stages A to C, the divider lanes, stages E to K, then the output buffer.
// Throughput: one ray per cycle while in_stall is low; the six bound quotients
//   run in six divider lanes retiring two quotient bits per stage, and the hit
//   points go through six 32x32 multipliers.
// Stall: a two-entry output buffer catches results; when both are full the
//   whole pipeline holds and in_stall rises, nothing is lost or repeated.
// Reset: synchronous active low; clears all valid bits, center to zero and
//   edge to 1.0.
module ray_box_slab_intersect (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [rbs_pkg::CW-1:0] in_org_x,
  input  logic signed [rbs_pkg::CW-1:0] in_org_y,
  input  logic signed [rbs_pkg::CW-1:0] in_org_z,
  input  logic signed [rbs_pkg::CW-1:0] in_dir_x,
  input  logic signed [rbs_pkg::CW-1:0] in_dir_y,
  input  logic signed [rbs_pkg::CW-1:0] in_dir_z,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic signed [rbs_pkg::CW-1:0] out_t_entry,
  output logic signed [rbs_pkg::CW-1:0] out_t_exit,
  output logic [2:0]                  out_entry_face,
  output logic [2:0]                  out_exit_face,
  input  logic                        cfg_we,
  input  logic [rbs_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [rbs_pkg::CW-1:0]      cfg_wdata
);
  import rbs_pkg::*;

  typedef struct packed {
    logic [2:0][CW-1:0] o;
    logic [2:0][CW-1:0] dmag;
    logic [2:0]         dneg;
    logic [5:0]         qneg;
    logic [2:0]         dz;
    logic [2:0]         ins;
  } side_t;

  function automatic logic signed [BW-1:0] bound_lo(input logic [CW-1:0] c,
                                                    input logic [EW-1:0] e);
    return $signed({{2{c[CW-1]}}, c}) - $signed({3'b000, 1'b0, e[EW-1:1]});
  endfunction

  function automatic logic signed [BW-1:0] bound_hi(input logic [CW-1:0] c,
                                                    input logic [EW-1:0] e);
    logic [EW-1:0] up;
    up = e - {1'b0, e[EW-1:1]};
    return $signed({{2{c[CW-1]}}, c}) + $signed({3'b000, up});
  endfunction

  logic en;

  // ---------------- configuration ----------------
  logic [CW-1:0]        ctr_r   [3];
  logic [CW-1:0]        ctr_nxt [3];
  logic [EW-1:0]        edge_r, edge_nxt;
  logic signed [BW-1:0] lo_r [3], lo_nxt [3];
  logic signed [BW-1:0] hi_r [3], hi_nxt [3];

  // Take register writes, refresh bounds from the new values
  always_comb begin
    for (int k = 0; k < 3; k++) ctr_nxt[k] = ctr_r[k];
    edge_nxt = edge_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X:  ctr_nxt[0] = cfg_wdata;
        REG_CENTER_Y:  ctr_nxt[1] = cfg_wdata;
        REG_CENTER_Z:  ctr_nxt[2] = cfg_wdata;
        REG_EDGE_SIZE: edge_nxt   = cfg_wdata[EW-1:0];
        default:       edge_nxt   = edge_r;
      endcase
    end
    for (int k = 0; k < 3; k++) begin
      lo_nxt[k] = bound_lo(ctr_nxt[k], edge_nxt);
      hi_nxt[k] = bound_hi(ctr_nxt[k], edge_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_r <= EDGE_RESET;
      for (int k = 0; k < 3; k++) begin
        ctr_r[k] <= '0;
        lo_r[k]  <= bound_lo('0, EDGE_RESET);
        hi_r[k]  <= bound_hi('0, EDGE_RESET);
      end
    end else begin
      edge_r <= edge_nxt;
      for (int k = 0; k < 3; k++) begin
        ctr_r[k] <= ctr_nxt[k];
        lo_r[k]  <= lo_nxt[k];
        hi_r[k]  <= hi_nxt[k];
      end
    end
  end

  // ---------------- stage A: capture request ----------------
  logic                 pa_v_r;
  logic signed [CW-1:0] pa_o_r [3];
  logic signed [CW-1:0] pa_d_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      pa_o_r[0] <= in_org_x;
      pa_o_r[1] <= in_org_y;
      pa_o_r[2] <= in_org_z;
      pa_d_r[0] <= in_dir_x;
      pa_d_r[1] <= in_dir_y;
      pa_d_r[2] <= in_dir_z;
    end
  end

  // ---------------- stage B: bound minus origin ----------------
  logic                   pb_v_r;
  logic signed [NUMW-1:0] pb_num_r [6];
  logic signed [CW-1:0]   pb_o_r [3];
  logic signed [CW-1:0]   pb_d_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pb_num_r[2*k]   <= NUMW'(lo_r[k]) - NUMW'(pa_o_r[k]);
        pb_num_r[2*k+1] <= NUMW'(hi_r[k]) - NUMW'(pa_o_r[k]);
        pb_o_r[k]       <= pa_o_r[k];
        pb_d_r[k]       <= pa_d_r[k];
      end
    end
  end

  // ---------------- stage C: magnitudes and signs ----------------
  logic            pc_v_r;
  logic [MAGW-1:0] pc_mag_r [6];
  logic [CW-1:0]   pc_dmag_r [3];
  side_t           pc_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 6; l++) begin
        pc_mag_r[l] <= pb_num_r[l][NUMW-1] ? MAGW'(-pb_num_r[l]) : MAGW'(pb_num_r[l]);
        pc_side_r.qneg[l] <= pb_num_r[l][NUMW-1] ^ pb_d_r[l/2][CW-1];
      end
      for (int k = 0; k < 3; k++) begin
        pc_dmag_r[k]        <= pb_d_r[k][CW-1] ? CW'(-pb_d_r[k]) : CW'(pb_d_r[k]);
        pc_side_r.dmag[k]   <= pb_d_r[k][CW-1] ? CW'(-pb_d_r[k]) : CW'(pb_d_r[k]);
        pc_side_r.dneg[k]   <= pb_d_r[k][CW-1];
        pc_side_r.dz[k]     <= (pb_d_r[k] == '0);
        pc_side_r.ins[k]    <= (pb_num_r[2*k] <= 0) && (pb_num_r[2*k+1] >= 0);
        pc_side_r.o[k]      <= pb_o_r[k];
      end
    end
  end

  // ---------------- divider lanes ----------------
  logic [CW-1:0] div_quo [6];
  logic          div_sat [6];

  for (genvar g = 0; g < 6; g++) begin : g_div
    rbs_div u_div (
      .clk   (clk),
      .en    (en),
      .mag_i (pc_mag_r[g]),
      .den_i (pc_dmag_r[g/2]),
      .quo_o (div_quo[g]),
      .sat_o (div_sat[g])
    );
  end

  // Side data rides alongside the divider stages
  logic  dv_v_r   [0:DIV_ST];
  side_t side_r   [0:DIV_ST];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= pc_side_r;
      for (int s = 1; s <= DIV_ST; s++) side_r[s] <= side_r[s-1];
    end
  end

  // ---------------- stage E: saturate and sign quotients ----------------
  logic                 pe_v_r;
  logic signed [CW-1:0] pe_t_r [6];
  side_t                pe_side_r;
  logic signed [CW-1:0] pe_t_nxt [6];

  always_comb begin
    for (int l = 0; l < 6; l++) begin
      logic big;
      big = div_sat[l] || (div_quo[l][CW-1] && (div_quo[l][CW-2:0] != '0));
      if (side_r[DIV_ST].qneg[l]) begin
        pe_t_nxt[l] = big ? T_MIN : -$signed(div_quo[l]);
      end else begin
        pe_t_nxt[l] = (big || div_quo[l][CW-1]) ? T_MAX : $signed(div_quo[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pe_t_r    <= pe_t_nxt;
      pe_side_r <= side_r[DIV_ST];
    end
  end

  // ---------------- stage F: order each slab ----------------
  logic                 pf_v_r;
  logic signed [CW-1:0] pf_tn_r [3];
  logic signed [CW-1:0] pf_tf_r [3];
  logic [2:0]           pf_out_r;
  side_t                pf_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (pe_side_r.dz[k]) begin
          pf_tn_r[k] <= T_MIN;
          pf_tf_r[k] <= T_MAX;
        end else if (pe_t_r[2*k] > pe_t_r[2*k+1]) begin
          pf_tn_r[k] <= pe_t_r[2*k+1];
          pf_tf_r[k] <= pe_t_r[2*k];
        end else begin
          pf_tn_r[k] <= pe_t_r[2*k];
          pf_tf_r[k] <= pe_t_r[2*k+1];
        end
        pf_out_r[k] <= pe_side_r.dz[k] && !pe_side_r.ins[k];
      end
      pf_side_r <= pe_side_r;
    end
  end

  // ---------------- stage G: narrow interval ----------------
  logic                 pg_v_r;
  logic signed [CW-1:0] pg_tn_r, pg_tf_r;
  logic                 pg_miss_r;
  side_t                pg_side_r;
  logic signed [CW-1:0] tn01, tf01;

  always_comb begin
    tn01 = (pf_tn_r[1] > pf_tn_r[0]) ? pf_tn_r[1] : pf_tn_r[0];
    tf01 = (pf_tf_r[1] < pf_tf_r[0]) ? pf_tf_r[1] : pf_tf_r[0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pg_tn_r   <= (pf_tn_r[2] > tn01) ? pf_tn_r[2] : tn01;
      pg_tf_r   <= (pf_tf_r[2] < tf01) ? pf_tf_r[2] : tf01;
      pg_miss_r <= |pf_out_r;
      pg_side_r <= pf_side_r;
    end
  end

  // ---------------- stage H: miss test, distance magnitudes ----------------
  logic                 ph_v_r;
  logic signed [CW-1:0] ph_tn_r, ph_tf_r;
  logic                 ph_miss_r;
  logic [CW-1:0]        ph_tmag_r [2];
  logic [1:0]           ph_tneg_r;
  side_t                ph_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ph_tn_r      <= pg_tn_r;
      ph_tf_r      <= pg_tf_r;
      ph_miss_r    <= pg_miss_r || (pg_tn_r > pg_tf_r) || pg_tf_r[CW-1];
      ph_tmag_r[0] <= pg_tn_r[CW-1] ? CW'(-pg_tn_r) : CW'(pg_tn_r);
      ph_tmag_r[1] <= pg_tf_r[CW-1] ? CW'(-pg_tf_r) : CW'(pg_tf_r);
      ph_tneg_r    <= {pg_tf_r[CW-1], pg_tn_r[CW-1]};
      ph_side_r    <= pg_side_r;
    end
  end

  // ---------------- stage I: t * dir products ----------------
  logic                 pi_v_r;
  logic signed [CW-1:0] pi_tn_r, pi_tf_r;
  logic                 pi_miss_r;
  logic [PRODW-1:0]     pi_prod_r [2][3];
  logic                 pi_pneg_r [2][3];
  logic [2:0][CW-1:0]   pi_o_r;
  logic [2*CW-1:0]      full_prod [2][3];

  always_comb begin
    for (int h = 0; h < 2; h++) begin
      for (int k = 0; k < 3; k++) begin
        full_prod[h][k] = {{CW{1'b0}}, ph_tmag_r[h]} * {{CW{1'b0}}, ph_side_r.dmag[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int h = 0; h < 2; h++) begin
        for (int k = 0; k < 3; k++) begin
          pi_prod_r[h][k] <= full_prod[h][k][2*CW-1:FB];
          pi_pneg_r[h][k] <= ph_tneg_r[h] ^ ph_side_r.dneg[k];
        end
      end
      pi_tn_r   <= ph_tn_r;
      pi_tf_r   <= ph_tf_r;
      pi_miss_r <= ph_miss_r;
      pi_o_r    <= ph_side_r.o;
    end
  end

  // ---------------- stage J: hit points ----------------
  logic                 pj_v_r;
  logic signed [CW-1:0] pj_tn_r, pj_tf_r;
  logic                 pj_miss_r;
  logic signed [PW-1:0] pj_p_r [2][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int h = 0; h < 2; h++) begin
        for (int k = 0; k < 3; k++) begin
          if (pi_pneg_r[h][k]) begin
            pj_p_r[h][k] <= PW'($signed(pi_o_r[k])) - $signed({2'b00, pi_prod_r[h][k]});
          end else begin
            pj_p_r[h][k] <= PW'($signed(pi_o_r[k])) + $signed({2'b00, pi_prod_r[h][k]});
          end
        end
      end
      pj_tn_r   <= pi_tn_r;
      pj_tf_r   <= pi_tf_r;
      pj_miss_r <= pi_miss_r;
    end
  end

  // ---------------- stage K: face tolerance tests ----------------
  logic                 pk_v_r;
  logic signed [CW-1:0] pk_tn_r, pk_tf_r;
  logic                 pk_miss_r;
  logic [2:0]           pk_lo_pass_r [2];
  logic [2:0]           pk_hi_pass_r [2];
  logic signed [DW-1:0] dlo [2][3];
  logic signed [DW-1:0] dhi [2][3];

  always_comb begin
    for (int h = 0; h < 2; h++) begin
      for (int k = 0; k < 3; k++) begin
        dlo[h][k] = DW'(pj_p_r[h][k]) - DW'(lo_r[k]);
        dhi[h][k] = DW'(pj_p_r[h][k]) - DW'(hi_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int h = 0; h < 2; h++) begin
        for (int k = 0; k < 3; k++) begin
          pk_lo_pass_r[h][k] <= (dlo[h][k] <= FACE_TOL) && (dlo[h][k] >= -FACE_TOL);
          pk_hi_pass_r[h][k] <= (dhi[h][k] <= FACE_TOL) && (dhi[h][k] >= -FACE_TOL);
        end
      end
      pk_tn_r   <= pj_tn_r;
      pk_tf_r   <= pj_tf_r;
      pk_miss_r <= pj_miss_r;
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_v_r <= 1'b0;
      pb_v_r <= 1'b0;
      pc_v_r <= 1'b0;
      pe_v_r <= 1'b0;
      pf_v_r <= 1'b0;
      pg_v_r <= 1'b0;
      ph_v_r <= 1'b0;
      pi_v_r <= 1'b0;
      pj_v_r <= 1'b0;
      pk_v_r <= 1'b0;
      for (int s = 0; s <= DIV_ST; s++) dv_v_r[s] <= 1'b0;
    end else if (en) begin
      pa_v_r    <= in_valid;
      pb_v_r    <= pa_v_r;
      pc_v_r    <= pb_v_r;
      dv_v_r[0] <= pc_v_r;
      for (int s = 1; s <= DIV_ST; s++) dv_v_r[s] <= dv_v_r[s-1];
      pe_v_r    <= dv_v_r[DIV_ST];
      pf_v_r    <= pe_v_r;
      pg_v_r    <= pf_v_r;
      ph_v_r    <= pg_v_r;
      pi_v_r    <= ph_v_r;
      pj_v_r    <= pi_v_r;
      pk_v_r    <= pj_v_r;
    end
  end

  // ---------------- output buffer ----------------
  res_t res_nxt;
  res_t out_r, skid_r;
  logic out_v_r, skid_v_r;
  logic push;

  // Encode faces, zero everything on a miss
  always_comb begin
    res_nxt = '0;
    if (!pk_miss_r) begin
      res_nxt.hit        = 1'b1;
      res_nxt.t_entry    = pk_tn_r;
      res_nxt.t_exit     = pk_tf_r;
      res_nxt.entry_face = face_code(pk_lo_pass_r[0], pk_hi_pass_r[0]);
      res_nxt.exit_face  = face_flip(face_code(pk_lo_pass_r[1], pk_hi_pass_r[1]));
    end
  end

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;
  assign push     = en && pk_v_r;

  // Hold a stalled result, park the next one in the skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && out_stall) begin
      if (push) skid_v_r <= 1'b1;
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && out_stall) begin
      if (push) skid_r <= res_nxt;
    end else if (skid_v_r) begin
      out_r <= skid_r;
    end else if (push) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid      = out_v_r;
  assign out_hit        = out_r.hit;
  assign out_t_entry    = out_r.t_entry;
  assign out_t_exit     = out_r.t_exit;
  assign out_entry_face = out_r.entry_face;
  assign out_exit_face  = out_r.exit_face;

endmodule

// ===== rtl/core/rbs_check.sv =====
// Port-level checks for ray_box_slab_intersect, bound to the top level.
// Depends on rbs_pkg.
module rbs_check (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_hit,
  input logic signed [rbs_pkg::CW-1:0] out_t_entry,
  input logic signed [rbs_pkg::CW-1:0] out_t_exit,
  input logic [2:0]                    out_entry_face,
  input logic [2:0]                    out_exit_face
);
  import rbs_pkg::*;

  // Drop pending results at reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Hold a stalled result
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  // A miss carries all zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_t_entry == '0 && out_t_exit == '0 &&
      out_entry_face == FACE_NONE && out_exit_face == FACE_NONE)
    else $error("miss with nonzero fields");

  // A hit has an ordered interval that ends in front of the origin
  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_t_entry <= out_t_exit && !out_t_exit[CW-1])
    else $error("hit interval out of order");

endmodule

bind ray_box_slab_intersect rbs_check u_rbs_check (.*);
